### hw/rtl/atkdith_pkg.sv
// shared types, constants and helpers for the atkinson dither bitmap core
`default_nettype none

package atkdith_pkg;

    // default line capacity in pixels
    localparam int MAX_WIDTH_DEF = 256;

    // configuration port shape
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int RW_W       = 9;
    localparam int RC_W       = 16;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_FORMAT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_USED   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_WIDTH    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT    = 3'd3;

    // register reset values
    localparam logic            PIXEL_FORMAT_RST = 1'b1;
    localparam logic            ALPHA_USED_RST   = 1'b0;
    localparam logic [RW_W-1:0] ROW_WIDTH_RST    = 9'd240;
    localparam logic [RC_W-1:0] ROW_COUNT_RST    = 16'd1;

    // gray weights and luma expansion constants
    localparam logic [16:0] W_RED     = 17'd77;
    localparam logic [16:0] W_GREEN   = 17'd150;
    localparam logic [16:0] W_BLUE    = 17'd29;
    localparam logic [16:0] RGB_ROUND = 17'd128;
    localparam logic [7:0]  Y_BLACK   = 8'd16;
    localparam logic [7:0]  Y_WHITE   = 8'd235;
    localparam logic [15:0] Y_GAIN    = 16'd149;
    localparam logic [15:0] Y_ROUND   = 16'd64;
    localparam logic [7:0]  WHITE     = 8'd255;
    localparam logic [7:0]  THRESHOLD = 8'd128;
    localparam logic [7:0]  MSB_MASK  = 8'h80;

    // diffused error: one eighth of the quantization error, -15..15
    localparam int ERR_W     = 5;
    localparam int ERR_SUM_W = 8;

    // one line store entry: last row's error and the row before it
    typedef struct packed {
        logic [ERR_W-1:0] err_prev;
        logic [ERR_W-1:0] err_pp;
    } t_line_entry;

    // sign extend an error term to the accumulator width
    function automatic logic [ERR_SUM_W-1:0] ext_err(input logic [ERR_W-1:0] v);
        return {{(ERR_SUM_W - ERR_W){v[ERR_W-1]}}, v};
    endfunction

endpackage

`default_nettype wire

### hw/rtl/atkinson_dither_to_bitmap_core.sv
// atkinson dither of a pixel stream into a packed one bit per pixel bitmap
// Usage:
//   Pixels enter in raster order on the input channel (i_in_valid / o_in_stall),
//   one transaction per pixel. Packed bytes leave on the output channel
//   (o_out_valid / i_out_stall), one transaction every eight pixels and at
//   the end of each row, with the byte column, the row and an image done flag.
//   A byte passes from the pixel that completes it through the input register,
//   the gray stage and the result register before it is valid at the output.
//   Throughput: one pixel per cycle while the output is not stalled; the error
//   feedback loop through the window registers and the line store adds no stall.
//   The line store keeps, per column, the errors of the previous two rows; the
//   first row of an image ignores its contents, so no clearing pass is needed.
//   Reset puts the registers to their defaults and starts a new image.
//   Any configuration write also starts a new image; write only when idle.
//   When the receiver stalls, the result register holds its byte, the pipeline
//   fills and o_in_stall rises once the input and gray stages are both full.
`default_nettype none

module atkinson_dither_to_bitmap_core #(
    parameter int MAX_WIDTH = atkdith_pkg::MAX_WIDTH_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [atkdith_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [atkdith_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                               i_in_valid,
    output logic                                    o_in_stall,
    input  wire logic [7:0]                         i_red_or_luma,
    input  wire logic [7:0]                         i_green,
    input  wire logic [7:0]                         i_blue,
    input  wire logic [7:0]                         i_opacity,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_stall,
    output logic [7:0]                              o_packed_byte,
    output logic [4:0]                              o_byte_column,
    output logic [15:0]                             o_row_number,
    output logic                                    o_image_done
);

    localparam int AW   = $clog2(MAX_WIDTH);
    localparam int CW   = $clog2(MAX_WIDTH + 1);
    localparam int WW   = (CW > atkdith_pkg::RW_W) ? CW : atkdith_pkg::RW_W;
    localparam int RC_W = atkdith_pkg::RC_W;
    localparam int EW   = atkdith_pkg::ERR_W;
    localparam int SW   = atkdith_pkg::ERR_SUM_W;

    // configuration registers
    logic                          r_pixel_format;
    logic                          r_alpha_used;
    logic [atkdith_pkg::RW_W-1:0]  r_row_width;
    logic [RC_W-1:0]               r_row_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pixel_format <= atkdith_pkg::PIXEL_FORMAT_RST;
            r_alpha_used   <= atkdith_pkg::ALPHA_USED_RST;
            r_row_width    <= atkdith_pkg::ROW_WIDTH_RST;
            r_row_count    <= atkdith_pkg::ROW_COUNT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                atkdith_pkg::CFG_PIXEL_FORMAT: r_pixel_format <= i_cfg_data[0];
                atkdith_pkg::CFG_ALPHA_USED:   r_alpha_used   <= i_cfg_data[0];
                atkdith_pkg::CFG_ROW_WIDTH:
                    r_row_width <= i_cfg_data[atkdith_pkg::RW_W-1:0];
                atkdith_pkg::CFG_ROW_COUNT:    r_row_count    <= i_cfg_data[RC_W-1:0];
                default: ;
            endcase
        end
    end

    // effective image size
    logic [WW-1:0]   rw_ext;
    logic [CW-1:0]   eff_w;
    logic [RC_W-1:0] eff_h;

    assign rw_ext = WW'(r_row_width);
    assign eff_w  = (r_row_width == '0)      ? CW'(1) :
                    (rw_ext > WW'(MAX_WIDTH)) ? CW'(MAX_WIDTH) : CW'(rw_ext);
    assign eff_h  = (r_row_count == '0) ? RC_W'(1) : r_row_count;

    // pipeline handshake
    logic r_a_valid, r_b_valid, r_o_valid;
    logic o_free, b_go, a_go, a_free, in_acc;

    assign o_free     = !r_o_valid || !i_out_stall;
    assign b_go       = r_b_valid && o_free;
    assign a_go       = r_a_valid && (!r_b_valid || b_go);
    assign a_free     = !r_a_valid || a_go;
    assign in_acc     = i_in_valid && a_free;
    assign o_in_stall = !a_free;

    // raster position of the next accepted pixel
    logic [AW-1:0]   r_f_x;
    logic [RC_W-1:0] r_f_row;
    logic [CW-1:0]   f_x_next;
    logic            f_row_end, f_last_row;

    assign f_x_next   = CW'(r_f_x) + CW'(1);
    assign f_row_end  = (f_x_next >= eff_w);
    assign f_last_row = ((RC_W + 1)'(r_f_row) + (RC_W + 1)'(1)) >= (RC_W + 1)'(eff_h);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we) begin
            r_f_x   <= '0;
            r_f_row <= '0;
        end else if (in_acc) begin
            if (f_row_end) begin
                r_f_x   <= '0;
                r_f_row <= f_last_row ? '0 : r_f_row + RC_W'(1);
            end else begin
                r_f_x   <= f_x_next[AW-1:0];
            end
        end
    end

    // input register
    logic [7:0]      r_a_r, r_a_g, r_a_b, r_a_op;
    logic [AW-1:0]   r_a_x;
    logic [RC_W-1:0] r_a_row;
    logic            r_a_row_end, r_a_last_row, r_a_first_row;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (a_free) begin
            r_a_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_a_r         <= i_red_or_luma;
            r_a_g         <= i_green;
            r_a_b         <= i_blue;
            r_a_op        <= i_opacity;
            r_a_x         <= r_f_x;
            r_a_row       <= r_f_row;
            r_a_row_end   <= f_row_end;
            r_a_last_row  <= f_last_row;
            r_a_first_row <= (r_f_row == '0);
        end
    end

    // gray level from rgb or studio-range luma
    logic [16:0] rgb_sum;
    logic [7:0]  y_diff;
    logic [15:0] y_prod;
    logic [7:0]  a_gray, a_alpha;

    assign rgb_sum = 17'(r_a_r) * atkdith_pkg::W_RED + 17'(r_a_g) * atkdith_pkg::W_GREEN
                   + 17'(r_a_b) * atkdith_pkg::W_BLUE + atkdith_pkg::RGB_ROUND;
    assign y_diff  = r_a_r - atkdith_pkg::Y_BLACK;
    assign y_prod  = 16'(y_diff) * atkdith_pkg::Y_GAIN + atkdith_pkg::Y_ROUND;

    always_comb begin
        if (r_pixel_format) begin
            a_gray = rgb_sum[15:8];
        end else if (r_a_r <= atkdith_pkg::Y_BLACK) begin
            a_gray = '0;
        end else if (r_a_r >= atkdith_pkg::Y_WHITE) begin
            a_gray = atkdith_pkg::WHITE;
        end else begin
            a_gray = y_prod[14:7];
        end
        a_alpha = (r_pixel_format || r_alpha_used) ? r_a_op : atkdith_pkg::WHITE;
    end

    // gray stage register, line store read issued alongside
    logic [7:0]      r_b_gray, r_b_alpha;
    logic [AW-1:0]   r_b_x;
    logic [RC_W-1:0] r_b_row;
    logic            r_b_row_end, r_b_last_row, r_b_rd_zero;
    logic [CW-1:0]   rd_addr_w;

    assign rd_addr_w = CW'(r_a_x) + CW'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (!r_b_valid || b_go) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_go) begin
            r_b_gray     <= a_gray;
            r_b_alpha    <= a_alpha;
            r_b_x        <= r_a_x;
            r_b_row      <= r_a_row;
            r_b_row_end  <= r_a_row_end;
            r_b_last_row <= r_a_last_row;
            r_b_rd_zero  <= r_a_row_end || r_a_first_row;
        end
    end

    // line store of the two previous rows' errors
    atkdith_pkg::t_line_entry wr_entry, rd_entry, rd_m;

    atkdith_line_mem #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_line_mem (
        .i_clk   (i_clk),
        .i_we    (b_go),
        .i_waddr (r_b_x),
        .i_wdata (wr_entry),
        .i_re    (a_go),
        .i_raddr (rd_addr_w[AW-1:0]),
        .o_rdata (rd_entry)
    );

    assign rd_m = r_b_rd_zero ? '0 : rd_entry;

    // composite over white
    logic [7:0]  inv_alpha;
    logic [15:0] mix;
    logic [16:0] mix_q;
    logic [7:0]  comp;

    assign inv_alpha = atkdith_pkg::WHITE - r_b_alpha;
    assign mix   = 16'(r_b_gray) * 16'(r_b_alpha) + 16'(inv_alpha) * 16'(atkdith_pkg::WHITE)
                 + 16'd127;
    assign mix_q = 17'(mix) + 17'(mix[15:8]) + 17'd1;

    always_comb begin
        if (r_b_alpha == '0) begin
            comp = atkdith_pkg::WHITE;
        end else if (r_b_alpha == atkdith_pkg::WHITE) begin
            comp = r_b_gray;
        end else begin
            comp = mix_q[15:8];
        end
    end

    // error window and row-local diffusion state
    logic [EW-1:0] r_w_m1, r_w_0, r_pp0, r_e1, r_e2, r_first_err, r_first_prev;
    logic [EW-1:0] n_w_m1, n_w_0, n_pp0, n_e1, n_e2, n_first_err, n_first_prev;
    logic [7:0]    r_part, n_part;

    // carried error, clamp, threshold and new error
    logic [SW-1:0] err_sum;
    logic [9:0]    pix_sum;
    logic [7:0]    pix_val, white_gap, part_next;
    logic [EW-1:0] err_now, first_err_sel, first_prev_sel;
    logic          black, emit;

    assign err_sum = atkdith_pkg::ext_err(r_w_m1) + atkdith_pkg::ext_err(r_w_0)
                   + atkdith_pkg::ext_err(rd_m.err_prev) + atkdith_pkg::ext_err(r_pp0)
                   + atkdith_pkg::ext_err(r_e1) + atkdith_pkg::ext_err(r_e2);
    assign pix_sum = {2'b00, comp} + {{2{err_sum[SW-1]}}, err_sum};

    always_comb begin
        if (pix_sum[9]) begin
            pix_val = '0;
        end else if (pix_sum[8]) begin
            pix_val = atkdith_pkg::WHITE;
        end else begin
            pix_val = pix_sum[7:0];
        end
    end

    assign black     = (pix_val < atkdith_pkg::THRESHOLD);
    assign white_gap = atkdith_pkg::WHITE - pix_val;
    assign err_now   = black ? {1'b0, pix_val[6:3]} : (EW'(0) - {1'b0, white_gap[6:3]});
    assign part_next = black ? (r_part | (atkdith_pkg::MSB_MASK >> r_b_x[2:0])) : r_part;
    assign emit      = (r_b_x[2:0] == 3'd7) || r_b_row_end;

    assign first_err_sel  = (r_b_x == '0) ? err_now : r_first_err;
    assign first_prev_sel = (r_b_x == '0) ? r_w_0   : r_first_prev;

    assign wr_entry.err_prev = err_now;
    assign wr_entry.err_pp   = r_w_0;

    // next window state
    always_comb begin
        n_w_m1       = r_w_m1;
        n_w_0        = r_w_0;
        n_pp0        = r_pp0;
        n_e1         = r_e1;
        n_e2         = r_e2;
        n_first_err  = r_first_err;
        n_first_prev = r_first_prev;
        n_part       = r_part;
        if (b_go) begin
            if (r_b_row_end) begin
                n_w_m1 = '0;
                n_e1   = '0;
                n_e2   = '0;
                if (r_b_last_row) begin
                    n_w_0 = '0;
                    n_pp0 = '0;
                end else begin
                    n_w_0 = first_err_sel;
                    n_pp0 = first_prev_sel;
                end
            end else begin
                n_w_m1 = r_w_0;
                n_w_0  = rd_m.err_prev;
                n_pp0  = rd_m.err_pp;
                n_e2   = r_e1;
                n_e1   = err_now;
            end
            n_first_err  = first_err_sel;
            n_first_prev = first_prev_sel;
            n_part       = emit ? '0 : part_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we) begin
            r_w_m1       <= '0;
            r_w_0        <= '0;
            r_pp0        <= '0;
            r_e1         <= '0;
            r_e2         <= '0;
            r_first_err  <= '0;
            r_first_prev <= '0;
            r_part       <= '0;
        end else begin
            r_w_m1       <= n_w_m1;
            r_w_0        <= n_w_0;
            r_pp0        <= n_pp0;
            r_e1         <= n_e1;
            r_e2         <= n_e2;
            r_first_err  <= n_first_err;
            r_first_prev <= n_first_prev;
            r_part       <= n_part;
        end
    end

    // result register
    logic [AW+4:0] x_wide, col_shift;
    logic [7:0]    r_o_byte;
    logic [4:0]    r_o_col;
    logic [15:0]   r_o_row;
    logic          r_o_done;

    assign x_wide    = (AW + 5)'(r_b_x);
    assign col_shift = x_wide >> 3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (o_free) begin
            r_o_valid <= b_go && emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_go && emit) begin
            r_o_byte <= part_next;
            r_o_col  <= col_shift[4:0];
            r_o_row  <= r_b_row;
            r_o_done <= r_b_row_end && r_b_last_row;
        end
    end

    assign o_out_valid   = r_o_valid;
    assign o_packed_byte = r_o_byte;
    assign o_byte_column = r_o_col;
    assign o_row_number  = r_o_row;
    assign o_image_done  = r_o_done;

`ifndef ASSERT_OFF
    // raster column stays inside the row
    a_col_in_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (CW'(r_f_x) < eff_w))
        else $error("column counter beyond row width");

    // the pixel after a row end starts the next row at column zero
    a_row_follow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (b_go && r_b_row_end && r_a_valid) |-> (r_a_x == '0))
        else $error("pixel after row end not at column zero");

    // a row starts with no row-local error carried in
    a_row_start_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (b_go && (r_b_x == '0)) |-> (r_e1 == '0 && r_e2 == '0 && r_w_m1 == '0))
        else $error("stale row-local error at row start");
`endif

endmodule

`default_nettype wire

### hw/rtl/atkdith_line_mem.sv
// error line store: one write port, one registered read port with write bypass
`default_nettype none

module atkdith_line_mem #(
    parameter int MAX_WIDTH = atkdith_pkg::MAX_WIDTH_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(MAX_WIDTH)-1:0] i_waddr,
    input  wire atkdith_pkg::t_line_entry i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(MAX_WIDTH)-1:0] i_raddr,
    output atkdith_pkg::t_line_entry      o_rdata
);

    localparam int AW    = $clog2(MAX_WIDTH);
    localparam int DEPTH = 2 ** AW;

    atkdith_pkg::t_line_entry r_mem [DEPTH];
    atkdith_pkg::t_line_entry r_rdata;

    // write, and read with the entry being written passed straight through
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            if (i_we && (i_waddr == i_raddr)) begin
                r_rdata <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_raddr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire
